[rtl/core/mpool_pkg.sv]
package mpool_pkg;

  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 12;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_IN_HEIGHT = 3'd0,
    REG_IN_WIDTH  = 3'd1,
    REG_IN_CHANS  = 3'd2,
    REG_WIN_H     = 3'd3,
    REG_WIN_W     = 3'd4,
    REG_STEP_R    = 3'd5,
    REG_STEP_C    = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_DRAIN,
    BK_OUT
  } bk_state_t;

endpackage

[rtl/core/mpool_ram.sv]
module mpool_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/mpool_front.sv]
// Tracks raster position, writes each sample into the line store and flags
// window corners. Corner jobs go to a small queue for the back end.
module mpool_front #(
  parameter int MaxWidth = 256,
  parameter int MaxChannels = 64,
  parameter int MaxWindow = 4,
  parameter int SampleBits = 16,
  parameter int AddrBits = 16,
  parameter int JobBits = 40
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SampleBits-1:0] in_sample,
  input  logic                  restart,
  input  logic                  hold,
  input  logic [11:0]           h_eff,
  input  logic [12:0]           w_eff,
  input  logic [10:0]           c_eff,
  input  logic [4:0]            wh_eff,
  input  logic [4:0]            ww_eff,
  input  logic [2:0]            sr_eff,
  input  logic [2:0]            sc_eff,
  input  logic [11:0]           oh,
  input  logic [12:0]           ow,
  output logic                  wr_en,
  output logic [AddrBits-1:0]   wr_addr,
  output logic [SampleBits-1:0] wr_data,
  output logic                  job_push,
  output logic [JobBits-1:0]    job_data,
  input  logic                  job_full
);
  import mpool_pkg::*;

  localparam int SlotBits = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int ColBits = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int ChBits = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;

  logic [11:0] row_r, row_nxt;
  logic [ColBits-1:0] col_r, col_nxt;
  logic [ChBits-1:0] ch_r, ch_nxt;
  // vertical phase: (row - wh + 1) mod sr and output row, kept incrementally
  logic [2:0] rph_r, rph_nxt, cph_r, cph_nxt;
  logic [11:0] orow_r, orow_nxt;
  logic [12:0] ocol_r, ocol_nxt;
  logic [SlotBits-1:0] slot_r, slot_nxt;

  logic accept, row_ok, col_ok, corner, ch_end, col_end, row_end, last;
  logic [12:0] col_ext;

  // hold: job pending or window walk in progress, or grid size still being counted
  assign in_stall = job_full || hold;
  assign accept = in_valid && !in_stall;
  assign col_ext = 13'(col_r);
  assign row_ok = (13'(row_r) + 13'd1) >= 13'(wh_eff);
  assign col_ok = (col_ext + 13'd1) >= 13'(ww_eff);
  assign corner = row_ok && col_ok && rph_r == 3'd0 && cph_r == 3'd0;
  assign ch_end = (11'(ch_r) + 11'd1) >= c_eff;
  assign col_end = (col_ext + 13'd1) >= w_eff;
  assign row_end = (13'(row_r) + 13'd1) >= 13'(h_eff);
  assign last = (orow_r + 12'd1 == oh) && (ocol_r + 13'd1 == ow) && ch_end;

  assign wr_en = accept;
  assign wr_addr = AddrBits'({slot_r, col_r, ch_r});
  assign wr_data = in_sample;
  assign job_push = accept && corner;
  assign job_data = JobBits'({last, orow_r, ocol_r[ColBits-1:0], ch_r, slot_r, col_r});

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    ch_nxt = ch_r;
    rph_nxt = rph_r;
    cph_nxt = cph_r;
    orow_nxt = orow_r;
    ocol_nxt = ocol_r;
    slot_nxt = slot_r;
    if (accept) begin
      if (ch_end) begin
        ch_nxt = '0;
        if (col_end) begin
          col_nxt = '0;
          cph_nxt = '0;
          ocol_nxt = '0;
          if (row_end) begin
            row_nxt = '0;
            slot_nxt = '0;
            rph_nxt = '0;
            orow_nxt = '0;
          end else begin
            row_nxt = row_r + 12'd1;
            slot_nxt = (32'(slot_r) + 1 >= MaxWindow) ? '0 : slot_r + SlotBits'(1);
            if (row_ok) begin
              if (rph_r == 3'd0) begin
                orow_nxt = orow_r + 12'd1;
              end
              rph_nxt = (rph_r + 3'd1 >= sr_eff) ? 3'd0 : rph_r + 3'd1;
            end
          end
        end else begin
          col_nxt = col_r + ColBits'(1);
          if (col_ok) begin
            if (cph_r == 3'd0) begin
              ocol_nxt = ocol_r + 13'd1;
            end
            cph_nxt = (cph_r + 3'd1 >= sc_eff) ? 3'd0 : cph_r + 3'd1;
          end
        end
      end else begin
        ch_nxt = ch_r + ChBits'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      row_r <= '0;
      col_r <= '0;
      ch_r <= '0;
      rph_r <= '0;
      cph_r <= '0;
      orow_r <= '0;
      ocol_r <= '0;
      slot_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      ch_r <= ch_nxt;
      rph_r <= rph_nxt;
      cph_r <= cph_nxt;
      orow_r <= orow_nxt;
      ocol_r <= ocol_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

[rtl/core/mpool_queue.sv]
// Two-entry job queue between front and back.
module mpool_queue #(
  parameter int Width = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             restart,
  input  logic             push,
  input  logic [Width-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [Width-1:0] head
);

  logic [Width-1:0] ent_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;

  assign full = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head = ent_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

endmodule

[rtl/core/mpool_back.sv]
// Walks the window of one job through the line store read port, one read
// per cycle, keeps a running max and holds the result in an output register.
module mpool_back #(
  parameter int MaxWidth = 256,
  parameter int MaxChannels = 64,
  parameter int MaxWindow = 4,
  parameter int SampleBits = 16,
  parameter int AddrBits = 16,
  parameter int JobBits = 40
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  input  logic [JobBits-1:0]           job_data,
  output logic                         job_pop,
  output logic                         reading,
  input  logic [4:0]                   wh_eff,
  input  logic [4:0]                   ww_eff,
  output logic [AddrBits-1:0]          rd_addr,
  input  logic [SampleBits-1:0]        rd_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [SampleBits-1:0] out_max_value,
  output logic [11:0]                  out_row,
  output logic [7:0]                   out_col,
  output logic [5:0]                   out_chan,
  output logic                         out_frame_last
);
  import mpool_pkg::*;

  localparam int SlotBits = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int ColBits = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int ChBits = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;

  bk_state_t st_r, st_nxt;
  logic [4:0] kr_r, kr_nxt, kc_r, kc_nxt;
  logic rd_v_r;
  logic signed [SampleBits-1:0] best_r;
  logic [JobBits-1:0] job_r;
  logic [SlotBits-1:0] cslot, rslot;
  logic [ColBits-1:0] ccol, rcol;
  logic [ChBits-1:0] jch;
  logic [11:0] jrow;
  logic [ColBits-1:0] jocol;
  logic jlast, issue, walk_done;
  logic signed [SampleBits-1:0] rd_s;
  logic [5:0] sub_s;
  logic [13:0] sub_c;

  assign {jlast, jrow, jocol, jch, cslot, ccol} = job_r[SlotBits+ColBits+ChBits+ColBits+12:0];
  assign rd_s = rd_data;

  // slot and column of the current tap relative to the bottom-right corner
  assign sub_s = 6'(cslot) + 6'(MaxWindow) - 6'(wh_eff) + 6'd1 + 6'(kr_r);
  assign rslot = SlotBits'((32'(sub_s) >= MaxWindow) ? 32'(sub_s) - MaxWindow : 32'(sub_s));
  assign sub_c = 14'(ccol) + 14'(kc_r) + 14'd1 - 14'(ww_eff);
  assign rcol = sub_c[ColBits-1:0];
  assign rd_addr = AddrBits'({rslot, rcol, jch});

  assign issue = st_r == BK_READ;
  assign reading = issue;
  assign walk_done = (kc_r + 5'd1 >= ww_eff) && (kr_r + 5'd1 >= wh_eff);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE:  if (job_valid) st_nxt = BK_READ;
      BK_READ:  if (walk_done) st_nxt = BK_DRAIN;
      BK_DRAIN: st_nxt = BK_OUT;
      BK_OUT:   if (!out_stall) st_nxt = job_valid ? BK_READ : BK_IDLE;
      default:  st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop = 1'b0;
    kr_nxt = kr_r;
    kc_nxt = kc_r;
    case (st_r)
      BK_IDLE: begin
        job_pop = job_valid;
        kr_nxt = '0;
        kc_nxt = '0;
      end
      BK_READ: begin
        if (kc_r + 5'd1 >= ww_eff) begin
          kc_nxt = '0;
          kr_nxt = kr_r + 5'd1;
        end else begin
          kc_nxt = kc_r + 5'd1;
        end
      end
      BK_OUT: begin
        job_pop = !out_stall && job_valid;
        kr_nxt = '0;
        kc_nxt = '0;
      end
      default: ;
    endcase
  end

  assign out_valid = st_r == BK_OUT;
  assign out_max_value = best_r;
  assign out_row = jrow;
  assign out_col = 8'(jocol);
  assign out_chan = 6'(jch);
  assign out_frame_last = jlast;

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job_data;
      best_r <= {1'b1, {(SampleBits-1){1'b0}}};
    end else if (rd_v_r && rd_s > best_r) begin
      best_r <= rd_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      kr_r <= '0;
      kc_r <= '0;
      rd_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      kr_r <= kr_nxt;
      kc_r <= kc_nxt;
      rd_v_r <= issue;
    end
  end

endmodule

[rtl/core/max_pool_2d_stream.sv]
// Results: a corner sample gives one result once the back end has read its
// window; other samples give none.
// Throughput: one sample per cycle in, but after a corner sample the input
// stalls while its job waits and its window is read. A held result keeps
// the back end in its output state, and the next corner job waits for it.
// Reset: counters clear and config takes its defaults; the line store is
// not cleared. A config write restarts the frame; after reset or a config
// write the input stalls until the output grid size is counted.
module max_pool_2d_stream #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_WINDOW = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        out_max_value,
  output logic [11:0]                          out_row,
  output logic [7:0]                           out_col,
  output logic [5:0]                           out_chan,
  output logic                                 out_frame_last,
  input  logic                                 cfg_wr_en,
  input  logic [mpool_pkg::CfgIdxBits-1:0]     cfg_index,
  input  logic [mpool_pkg::CfgDataBits-1:0]    cfg_data
);
  import mpool_pkg::*;

  localparam int SlotBits = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int ColBits = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ChBits = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int AddrBits = SlotBits + ColBits + ChBits;
  localparam int Depth = 1 << AddrBits;
  localparam int JobBits = 1 + 12 + ColBits + ChBits + SlotBits + ColBits;

  logic [11:0] hgt_r;
  logic [8:0] wid_r;
  logic [6:0] chn_r;
  logic [2:0] wh_r, ww_r, sr_r, sc_r;
  logic restart;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hgt_r <= 12'd32;
      wid_r <= 9'd32;
      chn_r <= 7'd8;
      wh_r <= 3'd2;
      ww_r <= 3'd2;
      sr_r <= 3'd2;
      sc_r <= 3'd2;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_IN_HEIGHT: hgt_r <= cfg_data[11:0];
        REG_IN_WIDTH:  wid_r <= cfg_data[8:0];
        REG_IN_CHANS:  chn_r <= cfg_data[6:0];
        REG_WIN_H:     wh_r <= cfg_data[2:0];
        REG_WIN_W:     ww_r <= cfg_data[2:0];
        REG_STEP_R:    sr_r <= cfg_data[2:0];
        REG_STEP_C:    sc_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_wr_en && (cfg_index <= CfgIdxBits'(REG_STEP_C));

  // Clamped, registered settings. Config written only when idle; user-enforced.
  logic [11:0] h_eff_r, oh_r;
  logic [12:0] w_eff_r, ow_r;
  logic [10:0] c_eff_r;
  logic [4:0] wh_eff_r, ww_eff_r;
  logic [2:0] sr_eff_r, sc_eff_r;
  logic [12:0] w_tmp;
  logic [10:0] c_tmp;
  logic [4:0] wh_tmp, ww_tmp;
  logic [2:0] sr_tmp, sc_tmp;

  always_comb begin
    w_tmp = (wid_r == 9'd0) ? 13'd1 : 13'(wid_r);
    if (32'(w_tmp) > MAX_WIDTH) w_tmp = 13'(MAX_WIDTH);
    c_tmp = (chn_r == 7'd0) ? 11'd1 : 11'(chn_r);
    if (32'(c_tmp) > MAX_CHANNELS) c_tmp = 11'(MAX_CHANNELS);
    wh_tmp = (wh_r == 3'd0) ? 5'd1 : 5'(wh_r);
    if (32'(wh_tmp) > MAX_WINDOW) wh_tmp = 5'(MAX_WINDOW);
    ww_tmp = (ww_r == 3'd0) ? 5'd1 : 5'(ww_r);
    if (32'(ww_tmp) > MAX_WINDOW) ww_tmp = 5'(MAX_WINDOW);
    sr_tmp = (sr_r == 3'd0) ? 3'd1 : sr_r;
    sc_tmp = (sc_r == 3'd0) ? 3'd1 : sc_r;
  end

  // Output grid size by repeated subtraction after each config change.
  // 1ffd: wait for the effective settings to register, 1fff: start, 1ffe: done.
  logic [12:0] hrem_r, wrem_r;
  logic [11:0] ohc_r;
  logic [12:0] owc_r;

  always_ff @(posedge clk) begin
    h_eff_r <= (hgt_r == 12'd0) ? 12'd1 : hgt_r;
    w_eff_r <= w_tmp;
    c_eff_r <= c_tmp;
    wh_eff_r <= wh_tmp;
    ww_eff_r <= ww_tmp;
    sr_eff_r <= sr_tmp;
    sc_eff_r <= sc_tmp;
    if (!rst_n || restart) begin
      hrem_r <= 13'h1ffd;
      wrem_r <= 13'h1ffd;
      ohc_r <= '0;
      owc_r <= '0;
      oh_r <= '0;
      ow_r <= '0;
    end else begin
      if (hrem_r == 13'h1ffd) begin
        hrem_r <= 13'h1fff;
      end else if (hrem_r == 13'h1fff) begin
        if (13'(h_eff_r) >= 13'(wh_eff_r) && h_eff_r != 12'd0) begin
          hrem_r <= 13'(h_eff_r) - 13'(wh_eff_r);
          ohc_r <= 12'd1;
        end else begin
          hrem_r <= 13'h1ffe;
          ohc_r <= 12'd0;
        end
      end else if (hrem_r != 13'h1ffe) begin
        if (hrem_r >= 13'(sr_eff_r)) begin
          hrem_r <= hrem_r - 13'(sr_eff_r);
          ohc_r <= ohc_r + 12'd1;
        end else begin
          hrem_r <= 13'h1ffe;
        end
      end
      oh_r <= ohc_r;
      if (wrem_r == 13'h1ffd) begin
        wrem_r <= 13'h1fff;
      end else if (wrem_r == 13'h1fff) begin
        if (w_eff_r != 13'd0 && w_eff_r >= 13'(ww_eff_r)) begin
          wrem_r <= w_eff_r - 13'(ww_eff_r);
          owc_r <= 13'd1;
        end else begin
          wrem_r <= 13'h1ffe;
          owc_r <= 13'd0;
        end
      end else if (wrem_r != 13'h1ffe) begin
        if (wrem_r >= 13'(sc_eff_r)) begin
          wrem_r <= wrem_r - 13'(sc_eff_r);
          owc_r <= owc_r + 13'd1;
        end else begin
          wrem_r <= 13'h1ffe;
        end
      end
      ow_r <= owc_r;
    end
  end

  logic                   wr_en;
  logic [AddrBits-1:0]    wr_addr, rd_addr;
  logic [SAMPLE_BITS-1:0] wr_data, rd_data;
  logic                   job_push, job_full, job_pop, job_valid;
  logic [JobBits-1:0]     job_in, job_head;
  logic                   bk_reading, grid_busy, in_hold;

  assign grid_busy = (hrem_r != 13'h1ffe) || (wrem_r != 13'h1ffe);
  // no new sample may overwrite a line store entry that a pending job still reads
  assign in_hold = grid_busy || job_valid || bk_reading;

  mpool_front #(
    .MaxWidth(MAX_WIDTH), .MaxChannels(MAX_CHANNELS), .MaxWindow(MAX_WINDOW),
    .SampleBits(SAMPLE_BITS), .AddrBits(AddrBits), .JobBits(JobBits)
  ) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_sample, .restart, .hold(in_hold),
    .h_eff(h_eff_r), .w_eff(w_eff_r), .c_eff(c_eff_r), .wh_eff(wh_eff_r),
    .ww_eff(ww_eff_r), .sr_eff(sr_eff_r), .sc_eff(sc_eff_r), .oh(oh_r), .ow(ow_r),
    .wr_en, .wr_addr, .wr_data, .job_push, .job_data(job_in), .job_full
  );

  mpool_queue #(.Width(JobBits)) u_queue (
    .clk, .rst_n, .restart, .push(job_push), .push_data(job_in), .full(job_full),
    .pop(job_pop), .not_empty(job_valid), .head(job_head)
  );

  mpool_ram #(.Width(SAMPLE_BITS), .Depth(Depth)) u_store (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
  );

  mpool_back #(
    .MaxWidth(MAX_WIDTH), .MaxChannels(MAX_CHANNELS), .MaxWindow(MAX_WINDOW),
    .SampleBits(SAMPLE_BITS), .AddrBits(AddrBits), .JobBits(JobBits)
  ) u_back (
    .clk, .rst_n, .job_valid, .job_data(job_head), .job_pop, .reading(bk_reading),
    .wh_eff(wh_eff_r), .ww_eff(ww_eff_r), .rd_addr, .rd_data,
    .out_valid, .out_stall, .out_max_value, .out_row, .out_col, .out_chan,
    .out_frame_last
  );

endmodule

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mpool_pkg::*;

  typedef struct packed {
    logic signed [15:0] max_value;
    logic [11:0] row;
    logic [7:0] col;
    logic [5:0] chan;
    logic last;
  } pool_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_max_value;
  logic [11:0] out_row;
  logic [7:0] out_col;
  logic [5:0] out_chan;
  logic out_frame_last;
  logic cfg_wr_en = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  max_pool_2d_stream dut (.*);

  // predictor state
  logic [15:0] line_mem [0:4*256*64-1];
  int unsigned p_row, p_col, p_ch;
  int unsigned c_h, c_w, c_c, c_wh, c_ww, c_sr, c_sc;
  pool_res_t pending_q[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  function automatic int unsigned atl1(int unsigned v);
    return v == 0 ? 1 : v;
  endfunction

  function automatic int unsigned clampv(int unsigned v, int unsigned hi);
    v = atl1(v);
    return v > hi ? hi : v;
  endfunction

  function automatic int unsigned slot_addr(int unsigned r, int unsigned c, int unsigned ch);
    return ((r % 4) * 256 + c) * 64 + ch;
  endfunction

  function automatic void pool_predict(logic signed [15:0] s);
    int unsigned h, w, c, wh, ww, sr, sc, top, left, oh, ow;
    logic signed [15:0] best;
    logic signed [15:0] v;
    pool_res_t res;
    h = atl1(c_h); w = clampv(c_w, 256); c = clampv(c_c, 64);
    wh = clampv(c_wh, 4); ww = clampv(c_ww, 4); sr = atl1(c_sr); sc = atl1(c_sc);
    line_mem[slot_addr(p_row, p_col, p_ch)] = s;
    if (p_row + 1 >= wh && p_col + 1 >= ww) begin
      top = p_row + 1 - wh;
      left = p_col + 1 - ww;
      if (top % sr == 0 && left % sc == 0) begin
        best = -16'sd32768;
        for (int kr = 0; kr < wh; kr++)
          for (int kc = 0; kc < ww; kc++) begin
            v = line_mem[slot_addr(top + kr, left + kc, p_ch)];
            if (v > best) best = v;
          end
        oh = (h >= wh) ? (h - wh) / sr + 1 : 0;
        ow = (w - ww) / sc + 1;
        res.max_value = best;
        res.row = 12'(top / sr);
        res.col = 8'(left / sc);
        res.chan = 6'(p_ch);
        res.last = (top / sr + 1 == oh) && (left / sc + 1 == ow) && (p_ch + 1 == c);
        pending_q.push_back(res);
      end
    end
    if (p_ch + 1 >= c) begin
      p_ch = 0;
      if (p_col + 1 >= w) begin
        p_col = 0;
        p_row = (p_row + 1 >= h) ? 0 : p_row + 1;
      end else p_col = p_col + 1;
    end else p_ch = p_ch + 1;
  endfunction

  // valid stays high after a transfer until the next idle cycle or pause
  task automatic send_sample(logic signed [15:0] s);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pool_predict(s);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CfgDataBits'(val);
    @(posedge clk);
    case (idx)
      REG_IN_HEIGHT: c_h = val & 12'hfff;
      REG_IN_WIDTH: c_w = val & 9'h1ff;
      REG_IN_CHANS: c_c = val & 7'h7f;
      REG_WIN_H: c_wh = val & 7;
      REG_WIN_W: c_ww = val & 7;
      REG_STEP_R: c_sr = val & 7;
      default: c_sc = val & 7;
    endcase
    p_row = 0; p_col = 0; p_ch = 0;
  endtask

  task automatic set_shape(int unsigned h, w, c, wh, ww, sr, sc);
    wait_drained();
    write_reg(REG_IN_HEIGHT, h);
    write_reg(REG_IN_WIDTH, w);
    write_reg(REG_IN_CHANS, c);
    write_reg(REG_WIN_H, wh);
    write_reg(REG_WIN_W, ww);
    write_reg(REG_STEP_R, sr);
    write_reg(REG_STEP_C, sc);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return -16'sd32768;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frames(int unsigned n);
    repeat (n) send_sample(rand_sample());
  endtask

  // extremes of the sample, every bit toggled
  task automatic test_directed();
    c_h = 32; c_w = 32; c_c = 8; c_wh = 2; c_ww = 2; c_sr = 2; c_sc = 2;
    set_shape(2, 2, 1, 2, 2, 2, 2);
    send_sample(-16'sd32768); send_sample(-16'sd32768);
    send_sample(-16'sd32768); send_sample(-16'sd32768);
    send_sample(16'sh7fff); send_sample(16'sh5555);
    send_sample(-16'sd1); send_sample(16'shaaaa);
    send_sample(16'sh0000); send_sample(-16'sd2);
    send_sample(16'sh0001); send_sample(16'sh8001);
    // window larger than the frame: nothing comes out
    set_shape(1, 3, 2, 2, 4, 1, 1);
    send_frames(12);
    // zero registers act as one
    set_shape(0, 0, 0, 0, 0, 0, 0);
    send_frames(4);
  endtask

  task automatic test_random_shapes(int unsigned budget);
    int unsigned h, w, c, wh, ww, n;
    while (budget > 0) begin
      wh = $urandom_range(1, 4); ww = $urandom_range(1, 4);
      h = $urandom_range(wh, wh + 5); w = $urandom_range(ww, ww + 6);
      c = $urandom_range(1, 5);
      set_shape(h, w, c, wh, ww, $urandom_range(1, 4), $urandom_range(1, 4));
      n = h * w * c * $urandom_range(1, 2);
      if (n > budget) n = budget;
      send_frames(n);
      budget -= n;
    end
  endtask

  task automatic test_extremes();
    // full width frame, tall frame, many channels, oversize registers
    set_shape(2, 256, 1, 2, 4, 2, 4);
    send_frames(2 * 256);
    set_shape(4095, 1, 64, 1, 1, 1, 1);
    send_frames(128);
    set_shape(1, 4, 64, 1, 4, 1, 1);
    send_frames(256);
    set_shape(3, 300, 100, 7, 7, 7, 7);
    send_frames(40);
  endtask

  task automatic test_backpressure();
    set_shape(4, 4, 2, 1, 1, 1, 1);
    send_idle_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      send_frames(32);
    join
    wait_drained();
    send_frames(32);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      out_stall <= hold_off || (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time,
                   {out_max_value, out_row, out_col, out_chan, out_frame_last});
          errors++;
        end else begin
          pool_res_t e;
          e = pending_q.pop_front();
          if (e != {out_max_value, out_row, out_col, out_chan, out_frame_last}) begin
            $display("%0t: mismatch exp val=%0d row=%0d col=%0d ch=%0d last=%0b",
                     $time, e.max_value, e.row, e.col, e.chan, e.last);
            $display("%0t:          act val=%0d row=%0d col=%0d ch=%0d last=%0b",
                     $time, out_max_value, out_row, out_col, out_chan, out_frame_last);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer or config write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle_pct = 19; recv_idle_pct = 63;
    test_random_shapes(230);
    send_idle_pct = 63; recv_idle_pct = 19;
    test_random_shapes(230);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_shapes(230);
    test_extremes();
    test_backpressure();
    wait_drained();
    if (errors == 0 && pending_q.size() == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end
endmodule
